FILE: hw/rtl/cfbs_pkg.sv
// cfbs_pkg: shared types and constants of the chained free-block stack
// no dependencies; used by every file under hw/rtl
package cfbs_pkg;

    localparam int BLOCK_W = 32;
    localparam int COUNT_W = 6;

    typedef enum logic [1:0] {
        KIND_ALLOC      = 2'd0,
        KIND_FREE       = 2'd1,
        KIND_REFILL_ENT = 2'd2,
        KIND_REFILL_END = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_REFILL   = 3'd2,
        ST_SPILLCNT = 3'd3,
        ST_SPILLENT = 3'd4,
        ST_FREED    = 3'd5,
        ST_BAD      = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_FREE_CHK,
        S_FREE_PUSH,
        S_SPILL_CNT,
        S_SPILL_ENT,
        S_EMIT
    } state_t;

    localparam logic [0:0] CFG_DATA_START  = 1'b0;
    localparam logic [0:0] CFG_VOLUME_SIZE = 1'b1;

endpackage

FILE: hw/rtl/cfbs_stack_mem.sv
// cfbs_stack_mem: single-write, single-read memory holding the free block stack
// depends on cfbs_pkg for the block width
module cfbs_stack_mem #(
    parameter int DEPTH = 50,
    parameter int AW    = 6
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [cfbs_pkg::BLOCK_W-1:0]  wdata,
    input  logic                          re,
    input  logic [AW-1:0]                 raddr,
    output logic [cfbs_pkg::BLOCK_W-1:0]  rdata
);

    logic [cfbs_pkg::BLOCK_W-1:0] mem [DEPTH];
    logic [cfbs_pkg::BLOCK_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data is held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/cfbs_range_chk.sv
// cfbs_range_chk: shared block-number range compare unit
// depends on cfbs_pkg for the block width
module cfbs_range_chk (
    input  logic [cfbs_pkg::BLOCK_W-1:0] value,
    input  logic [cfbs_pkg::BLOCK_W-1:0] data_start,
    input  logic [cfbs_pkg::BLOCK_W-1:0] volume_size,
    output logic                         bad
);

    // outside [data_start, volume_size)
    assign bad = (value < data_start) || (value >= volume_size);

endmodule

FILE: hw/rtl/chained_free_block_stack.sv
// chained_free_block_stack: top level, sequencer, state and output register
// depends on cfbs_pkg, cfbs_stack_mem and cfbs_range_chk
//
// Free-block cache in the classic chained style. An allocate pops the top
// block, skipping entries outside [data_start, volume_size); a zero entry or an
// empty stack answers no_space. Popping the last entry makes it the chain
// block: the block answers refill_request and then takes refill entry words
// and one refill finish word, which grants the chain block, or answers no_space
// when its count is zero or above STACK_DEPTH. A free pushes the block (after
// seeding a zero terminator on an empty stack) or answers bad when it is out of
// range; on a full stack it first streams the count and all STACK_DEPTH entries
// out. One item is worked at a time and in_stall stays high until its last
// result word has been loaded into the output register. Each pop is one stack
// memory read and one range compare; the spill reads one entry per cycle
// through the single memory read port while the output does not stall. An
// allocate or free while a refill is pending repeats refill_request; a refill
// entry word gives no result.
// Config writes are expected only while the block is idle.
module chained_free_block_stack #(
    parameter int STACK_DEPTH = 50
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config write port
    input  logic                          cfg_wen,
    input  logic [0:0]                    cfg_index,
    input  logic [cfbs_pkg::BLOCK_W-1:0]  cfg_data,
    // input word
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    kind,
    input  logic [cfbs_pkg::BLOCK_W-1:0]  block,
    input  logic [5:0]                    slot,
    input  logic [cfbs_pkg::COUNT_W-1:0]  refill_count,
    // result word
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [cfbs_pkg::BLOCK_W-1:0]  block_res,
    output logic [cfbs_pkg::COUNT_W-1:0]  count,
    output logic [cfbs_pkg::BLOCK_W-1:0]  total_free,
    output logic                          last
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [cfbs_pkg::COUNT_W-1:0] DEPTH_C = cfbs_pkg::COUNT_W'(STACK_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(STACK_DEPTH - 1);

    localparam int BW = cfbs_pkg::BLOCK_W;
    localparam int CW = cfbs_pkg::COUNT_W;

    // sequencer
    cfbs_pkg::state_t state_reg, state_next;

    // config registers
    logic [BW-1:0] start_reg;
    logic [BW-1:0] size_reg;

    // working state
    logic [BW-1:0]     blk_reg, blk_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [BW-1:0]     tally_reg, tally_next;
    logic              await_reg, await_next;
    logic [BW-1:0]     chain_reg, chain_next;
    logic [AW-1:0]     idx_reg, idx_next;
    cfbs_pkg::status_t res_status_reg, res_status_next;
    logic [BW-1:0]     res_block_reg, res_block_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    cfbs_pkg::status_t out_status_reg, out_status_next;
    logic [BW-1:0]     out_block_reg, out_block_next;
    logic [CW-1:0]     out_count_reg, out_count_next;
    logic [BW-1:0]     out_tally_reg, out_tally_next;
    logic              out_last_reg, out_last_next;

    // memory and compare unit hookup
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [BW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [BW-1:0] mem_rdata;
    logic [BW-1:0] chk_value;
    logic          chk_bad;

    logic          accept;
    logic          out_free;
    logic [CW-1:0] count_m1;
    logic [BW-1:0] tally_dec;

    assign accept    = in_valid && (state_reg == cfbs_pkg::S_IDLE);
    assign in_stall  = (state_reg != cfbs_pkg::S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign count_m1  = count_reg - CW'(1);
    // tally floors at zero on the way down
    assign tally_dec = (tally_reg == '0) ? '0 : (tally_reg - BW'(1));

    // one compare unit, fed by the popped entry or the block being freed
    assign chk_value = (state_reg == cfbs_pkg::S_ALLOC_CHK) ? mem_rdata : blk_reg;

    cfbs_range_chk u_range (
        .value       (chk_value),
        .data_start  (start_reg),
        .volume_size (size_reg),
        .bad         (chk_bad)
    );

    cfbs_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cfbs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (kind)
                        cfbs_pkg::KIND_ALLOC:
                            state_next = await_reg ? cfbs_pkg::S_EMIT : cfbs_pkg::S_ALLOC_RD;
                        cfbs_pkg::KIND_FREE:
                            state_next = await_reg ? cfbs_pkg::S_EMIT : cfbs_pkg::S_FREE_CHK;
                        cfbs_pkg::KIND_REFILL_END:
                            state_next = await_reg ? cfbs_pkg::S_EMIT : cfbs_pkg::S_IDLE;
                        default:
                            state_next = cfbs_pkg::S_IDLE;
                    endcase
                end
            end
            cfbs_pkg::S_ALLOC_RD:
            begin
                state_next = (count_reg == '0) ? cfbs_pkg::S_EMIT : cfbs_pkg::S_ALLOC_CHK;
            end
            cfbs_pkg::S_ALLOC_CHK:
            begin
                if (mem_rdata != '0 && chk_bad)
                begin
                    state_next = cfbs_pkg::S_ALLOC_RD;
                end
                else
                begin
                    state_next = cfbs_pkg::S_EMIT;
                end
            end
            cfbs_pkg::S_FREE_CHK:
            begin
                if (chk_bad)
                begin
                    state_next = cfbs_pkg::S_EMIT;
                end
                else if (count_reg >= DEPTH_C)
                begin
                    state_next = cfbs_pkg::S_SPILL_CNT;
                end
                else
                begin
                    state_next = cfbs_pkg::S_FREE_PUSH;
                end
            end
            cfbs_pkg::S_FREE_PUSH:
            begin
                state_next = cfbs_pkg::S_EMIT;
            end
            cfbs_pkg::S_SPILL_CNT:
            begin
                if (out_free)
                begin
                    state_next = cfbs_pkg::S_SPILL_ENT;
                end
            end
            cfbs_pkg::S_SPILL_ENT:
            begin
                if (out_free && idx_reg == LAST_IDX)
                begin
                    state_next = cfbs_pkg::S_FREE_PUSH;
                end
            end
            cfbs_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = cfbs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cfbs_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        blk_next        = blk_reg;
        count_next      = count_reg;
        tally_next      = tally_reg;
        await_next      = await_reg;
        chain_next      = chain_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;

        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_block_next  = out_block_reg;
        out_count_next  = out_count_reg;
        out_tally_next  = out_tally_reg;
        out_last_next   = out_last_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        case (state_reg)
            cfbs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    blk_next = block;
                    case (kind)
                        cfbs_pkg::KIND_ALLOC,
                        cfbs_pkg::KIND_FREE:
                        begin
                            // blocked on a refill: repeat the request
                            res_status_next = cfbs_pkg::ST_REFILL;
                            res_block_next  = chain_reg;
                        end
                        cfbs_pkg::KIND_REFILL_ENT:
                        begin
                            if (await_reg && slot < DEPTH_C)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = slot[AW-1:0];
                                mem_wdata = block;
                            end
                        end
                        cfbs_pkg::KIND_REFILL_END:
                        begin
                            if (await_reg)
                            begin
                                await_next = 1'b0;
                                if (refill_count == '0 || refill_count > DEPTH_C)
                                begin
                                    count_next      = '0;
                                    res_status_next = cfbs_pkg::ST_NOSPACE;
                                    res_block_next  = '0;
                                end
                                else
                                begin
                                    count_next      = refill_count;
                                    tally_next      = tally_dec;
                                    res_status_next = cfbs_pkg::ST_GRANTED;
                                    res_block_next  = chain_reg;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            cfbs_pkg::S_ALLOC_RD:
            begin
                if (count_reg == '0)
                begin
                    res_status_next = cfbs_pkg::ST_NOSPACE;
                    res_block_next  = '0;
                end
                else
                begin
                    count_next = count_m1;
                    mem_re     = 1'b1;
                    mem_raddr  = count_m1[AW-1:0];
                end
            end
            cfbs_pkg::S_ALLOC_CHK:
            begin
                if (mem_rdata == '0)
                begin
                    // zero terminator: list exhausted
                    res_status_next = cfbs_pkg::ST_NOSPACE;
                    res_block_next  = '0;
                end
                else if (!chk_bad)
                begin
                    if (count_reg == '0)
                    begin
                        // last entry is the chain block
                        await_next      = 1'b1;
                        chain_next      = mem_rdata;
                        res_status_next = cfbs_pkg::ST_REFILL;
                        res_block_next  = mem_rdata;
                    end
                    else
                    begin
                        tally_next      = tally_dec;
                        res_status_next = cfbs_pkg::ST_GRANTED;
                        res_block_next  = mem_rdata;
                    end
                end
            end
            cfbs_pkg::S_FREE_CHK:
            begin
                if (chk_bad)
                begin
                    res_status_next = cfbs_pkg::ST_BAD;
                    res_block_next  = blk_reg;
                end
                else if (count_reg == '0)
                begin
                    // seed the zero terminator
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = '0;
                    count_next = CW'(1);
                end
            end
            cfbs_pkg::S_FREE_PUSH:
            begin
                mem_we          = 1'b1;
                mem_waddr       = count_reg[AW-1:0];
                mem_wdata       = blk_reg;
                count_next      = count_reg + CW'(1);
                tally_next      = tally_reg + BW'(1);
                res_status_next = cfbs_pkg::ST_FREED;
                res_block_next  = blk_reg;
            end
            cfbs_pkg::S_SPILL_CNT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = cfbs_pkg::ST_SPILLCNT;
                    out_block_next  = '0;
                    out_count_next  = DEPTH_C;
                    out_tally_next  = tally_reg;
                    out_last_next   = 1'b0;
                    mem_re          = 1'b1;
                    mem_raddr       = '0;
                    idx_next        = '0;
                end
            end
            cfbs_pkg::S_SPILL_ENT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = cfbs_pkg::ST_SPILLENT;
                    out_block_next  = mem_rdata;
                    out_count_next  = CW'(idx_reg);
                    out_tally_next  = tally_reg;
                    out_last_next   = 1'b0;
                    if (idx_reg == LAST_IDX)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg + AW'(1);
                        idx_next  = idx_reg + AW'(1);
                    end
                end
            end
            cfbs_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_block_next  = res_block_reg;
                    out_count_next  = count_reg;
                    out_tally_next  = tally_reg;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfbs_pkg::S_IDLE;
            count_reg     <= '0;
            tally_reg     <= '0;
            await_reg     <= 1'b0;
            chain_reg     <= '0;
            out_valid_reg <= 1'b0;
            start_reg     <= '0;
            size_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tally_reg     <= tally_next;
            await_reg     <= await_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen && cfg_index == cfbs_pkg::CFG_DATA_START)
            begin
                start_reg <= cfg_data;
            end
            if (cfg_wen && cfg_index == cfbs_pkg::CFG_VOLUME_SIZE)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        blk_reg        <= blk_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        out_status_reg <= out_status_next;
        out_block_reg  <= out_block_next;
        out_count_reg  <= out_count_next;
        out_tally_reg  <= out_tally_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign block_res  = out_block_reg;
    assign count      = out_count_reg;
    assign total_free = out_tally_reg;
    assign last       = out_last_reg;

endmodule

FILE: hw/rtl/cfbs_checker.sv
// cfbs_checker: port-level assertions for the chained free-block stack
// depends on cfbs_pkg; bound to chained_free_block_stack at the end of this file
module cfbs_checker #(
    parameter int STACK_DEPTH = 50
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [2:0]                    status,
    input logic [cfbs_pkg::BLOCK_W-1:0]  block_res,
    input logic [cfbs_pkg::COUNT_W-1:0]  count,
    input logic                          last
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(block_res))
        else $error("stalled result word changed");

    // spill words never close an item
    a_spill_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cfbs_pkg::ST_SPILLCNT || status == cfbs_pkg::ST_SPILLENT)
        |-> !last)
        else $error("spill word marked last");

    // every other status is the single final word
    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cfbs_pkg::ST_GRANTED || status == cfbs_pkg::ST_NOSPACE ||
                      status == cfbs_pkg::ST_REFILL || status == cfbs_pkg::ST_FREED ||
                      status == cfbs_pkg::ST_BAD)
        |-> last)
        else $error("final word not marked last");

    // spill count always reports a full stack with no block
    a_spill_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == cfbs_pkg::ST_SPILLCNT
        |-> count == cfbs_pkg::COUNT_W'(STACK_DEPTH) && block_res == '0)
        else $error("bad spill count word");

    // a spill count word is followed by the entry for slot zero
    a_spill_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && status == cfbs_pkg::ST_SPILLCNT
        |=> !out_valid || (status == cfbs_pkg::ST_SPILLENT && count == '0))
        else $error("spill entries out of order");

endmodule

bind chained_free_block_stack cfbs_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_cfbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .block_res (block_res),
    .count     (count),
    .last      (last)
);

FILE: sim/testbench.sv
// testbench: self-checking bench for the chained free-block stack
// depends on cfbs_pkg and chained_free_block_stack; a scoreboard class predicts each result word

module testbench;

    localparam int DEPTH     = 50;
    // cycles with no word moving on either side before the run is called hung;
    //   the slowest legal gap is a long skip chain plus a stall burst
    localparam int STUCK_MAX = 4000;

    typedef struct packed {
        cfbs_pkg::status_t status;
        logic [31:0]       blk;
        logic [5:0]        cnt;
        logic [31:0]       tally;
        logic              last;
    } result_word_t;

    // scoreboard: own copy of the free-block cache and the words it must answer
    class free_list_board;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  entries[DEPTH];
        bit           written[DEPTH];
        int unsigned  depth_used;
        logic [31:0]  tally;
        bit           waiting;
        logic [31:0]  chain;
        result_word_t expected_words[$];
        int           errors;

        function new();
            lo         = 0;
            hi         = 0;
            depth_used = 0;
            tally      = 0;
            waiting    = 0;
            chain      = 0;
            errors     = 0;
            foreach (entries[i])
            begin
                entries[i] = 0;
                written[i] = 0;
            end
        endfunction

        function void write_reg(logic [0:0] idx, logic [31:0] value);
            if (idx == cfbs_pkg::CFG_DATA_START)
                lo = value;
            else
                hi = value;
        endfunction

        function bit off_volume(logic [31:0] b);
            return b < lo || b >= hi;
        endfunction

        function void drop_tally();
            if (tally != 0)
                tally--;
        endfunction

        function void queue_word(cfbs_pkg::status_t st, logic [31:0] b, int unsigned c);
            result_word_t w;
            w.status = st;
            w.blk    = b;
            w.cnt    = c[5:0];
            w.tally  = tally;
            w.last   = 1'b0;
            expected_words.push_back(w);
        endfunction

        // note an accepted input word and queue the result words it causes
        function void take_word(cfbs_pkg::kind_t k, logic [31:0] b, logic [5:0] s,
                                logic [5:0] c);
            int unsigned  n_old;
            logic [31:0]  popped;
            bit           done;
            result_word_t w;
            n_old = expected_words.size();
            done  = 0;
            if ((k == cfbs_pkg::KIND_ALLOC || k == cfbs_pkg::KIND_FREE) && waiting)
                queue_word(cfbs_pkg::ST_REFILL, chain, depth_used);
            else if (k == cfbs_pkg::KIND_ALLOC)
            begin
                while (!done)
                begin
                    if (depth_used == 0 || depth_used > DEPTH)
                    begin
                        depth_used = 0;
                        queue_word(cfbs_pkg::ST_NOSPACE, 0, 0);
                        done = 1;
                    end
                    else
                    begin
                        depth_used--;
                        popped = entries[depth_used];
                        if (popped == 0)
                        begin
                            queue_word(cfbs_pkg::ST_NOSPACE, 0, depth_used);
                            done = 1;
                        end
                        else if (!off_volume(popped))
                        begin
                            if (depth_used == 0)
                            begin
                                waiting = 1;
                                chain   = popped;
                                queue_word(cfbs_pkg::ST_REFILL, popped, 0);
                            end
                            else
                            begin
                                drop_tally();
                                queue_word(cfbs_pkg::ST_GRANTED, popped, depth_used);
                            end
                            done = 1;
                        end
                    end
                end
            end
            else if (k == cfbs_pkg::KIND_FREE)
            begin
                if (off_volume(b))
                    queue_word(cfbs_pkg::ST_BAD, b, depth_used);
                else
                begin
                    if (depth_used == 0)
                    begin
                        entries[0] = 0;
                        written[0] = 1;
                        depth_used = 1;
                    end
                    if (depth_used >= DEPTH)
                    begin
                        queue_word(cfbs_pkg::ST_SPILLCNT, 0, DEPTH);
                        for (int i = 0; i < DEPTH; i++)
                            queue_word(cfbs_pkg::ST_SPILLENT, entries[i], i);
                        depth_used = 0;
                    end
                    entries[depth_used] = b;
                    written[depth_used] = 1;
                    depth_used++;
                    tally++;
                    queue_word(cfbs_pkg::ST_FREED, b, depth_used);
                end
            end
            else if (waiting && k == cfbs_pkg::KIND_REFILL_ENT)
            begin
                if (s < DEPTH)
                begin
                    entries[s] = b;
                    written[s] = 1;
                end
            end
            else if (waiting)
            begin
                waiting = 0;
                if (c == 0 || c > DEPTH)
                begin
                    depth_used = 0;
                    queue_word(cfbs_pkg::ST_NOSPACE, 0, 0);
                end
                else
                begin
                    depth_used = c;
                    drop_tally();
                    queue_word(cfbs_pkg::ST_GRANTED, chain, depth_used);
                end
            end
            if (expected_words.size() > n_old)
            begin
                w      = expected_words.pop_back();
                w.last = 1'b1;
                expected_words.push_back(w);
            end
        endfunction

        // compare one accepted result word with the oldest expectation
        function void check_word(result_word_t got);
            result_word_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: status %0d block %0h count %0d tally %0d last %0b",
                             got.status, got.blk, got.cnt, got.tally, got.last);
                return;
            end
            want = expected_words.pop_front();
            if (got.status !== want.status || got.blk !== want.blk || got.cnt !== want.cnt ||
                got.tally !== want.tally || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected status %0d block %0h count %0d",
                              " tally %0d last %0b,",
                              " got status %0d block %0h count %0d tally %0d last %0b"},
                             want.status, want.blk, want.cnt, want.tally, want.last,
                             got.status, got.blk, got.cnt, got.tally, got.last);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_wen;
    logic [0:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         kind;
    logic [31:0]        block;
    logic [5:0]         slot;
    logic [5:0]         refill_count;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic [31:0]        block_res;
    logic [5:0]         count;
    logic [31:0]        total_free;
    logic               last;

    free_list_board     board = new();
    result_word_t       seen_word;
    bit                 gaps_on;

    chained_free_block_stack #(.STACK_DEPTH(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .block        (block),
        .slot         (slot),
        .refill_count (refill_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .block_res    (block_res),
        .count        (count),
        .total_free   (total_free),
        .last         (last)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // receiver side: random stall bursts while gaps are on
    initial
    begin
        int n;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1;
                n = $urandom_range(1, 12);
                repeat (n - 1) @(negedge clk);
            end
            else
                out_stall = 0;
        end
    end

    // sample both channels at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.take_word(cfbs_pkg::kind_t'(kind), block, slot, refill_count);
            if (out_valid && !out_stall)
            begin
                seen_word = {status, block_res, count, total_free, last};
                board.check_word(seen_word);
            end
        end
    end

    // hang detection: count edges where no word moves on either side
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_MAX)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // present one input word at a falling edge and hold it until taken;
    // valid stays high afterwards so a following word goes out back to back
    task automatic issue_word(cfbs_pkg::kind_t k, logic [31:0] b, logic [5:0] s,
                              logic [5:0] c);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid     = 1;
        kind         = k;
        block        = b;
        slot         = s;
        refill_count = c;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // park the sender until every expected word is out, then let a
    // trailing refill entry word drain
    task automatic drain_block();
        in_valid = 0;
        while (board.expected_words.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_volume(logic [31:0] first, logic [31:0] size);
        drain_block();
        cfg_wen   = 1;
        cfg_index = cfbs_pkg::CFG_DATA_START;
        cfg_data  = first;
        board.write_reg(cfbs_pkg::CFG_DATA_START, first);
        @(negedge clk);
        cfg_index = cfbs_pkg::CFG_VOLUME_SIZE;
        cfg_data  = size;
        board.write_reg(cfbs_pkg::CFG_VOLUME_SIZE, size);
        @(negedge clk);
        cfg_wen = 0;
    endtask

    // block numbers: mostly inside the volume, some on and just past its
    // edges, some zero and some anywhere
    function automatic logic [31:0] pick_block();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75 && board.lo < board.hi)
            return $urandom_range(board.hi - 1, board.lo);
        if (r < 80)
            return board.lo;
        if (r < 85)
            return board.hi - 1;
        if (r < 88)
            return board.lo - 1;
        if (r < 91)
            return board.hi;
        if (r < 94)
            return 0;
        return $urandom;
    endfunction

    // random traffic; while a chain read is pending most of the time the
    // refill is well formed: entry words for the low slots, then the count
    task automatic run_traffic(int items, int free_pct);
        int sent;
        int pick;
        int n;
        int prefix;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(0, 99);
            if (board.waiting)
            begin
                if (pick < 80)
                begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, DEPTH)
                                                     : $urandom_range(1, 10);
                    for (int i = 0; i < n; i++)
                    begin
                        // now and then an entry word aimed past the stack
                        if ($urandom_range(0, 15) == 0)
                            issue_word(cfbs_pkg::KIND_REFILL_ENT, $urandom,
                                       6'($urandom_range(DEPTH, 63)),
                                       6'($urandom_range(0, 63)));
                        issue_word(cfbs_pkg::KIND_REFILL_ENT, pick_block(), 6'(i),
                                   6'($urandom_range(0, 63)));
                    end
                    issue_word(cfbs_pkg::KIND_REFILL_END, $urandom,
                               6'($urandom_range(0, 63)), 6'(n));
                    sent += n + 1;
                end
                else if (pick < 88)
                begin
                    // chain read error, or a count larger than the stack
                    issue_word(cfbs_pkg::KIND_REFILL_END, $urandom, 6'($urandom_range(0, 63)),
                               6'(($urandom_range(0, 1) != 0) ? 0
                                                              : $urandom_range(DEPTH + 1, 63)));
                    sent++;
                end
                else if (pick < 94)
                begin
                    // finish at once over slots still holding older blocks
                    prefix = 0;
                    while (prefix < DEPTH && board.written[prefix])
                        prefix++;
                    issue_word(cfbs_pkg::KIND_REFILL_END, $urandom, 6'($urandom_range(0, 63)),
                               6'((prefix == 0) ? 0 : $urandom_range(1, prefix)));
                    sent++;
                end
                else
                begin
                    // allocate or free during the wait only repeats the request
                    issue_word(cfbs_pkg::kind_t'(pick[0] ? cfbs_pkg::KIND_FREE
                                                         : cfbs_pkg::KIND_ALLOC),
                               pick_block(), 6'($urandom_range(0, 63)),
                               6'($urandom_range(0, 63)));
                    sent++;
                end
            end
            else if (pick < 4)
            begin
                // refill words with no chain read pending are dropped
                issue_word(cfbs_pkg::kind_t'(pick[0] ? cfbs_pkg::KIND_REFILL_END
                                                     : cfbs_pkg::KIND_REFILL_ENT),
                           $urandom, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            end
            else
            begin
                issue_word(cfbs_pkg::kind_t'((pick < free_pct) ? cfbs_pkg::KIND_FREE
                                                               : cfbs_pkg::KIND_ALLOC),
                           pick_block(), 6'($urandom_range(0, 63)),
                           6'($urandom_range(0, 63)));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n        = 0;
        cfg_wen      = 0;
        cfg_index    = cfbs_pkg::CFG_DATA_START;
        cfg_data     = 0;
        in_valid     = 0;
        kind         = cfbs_pkg::KIND_ALLOC;
        block        = 0;
        slot         = 0;
        refill_count = 0;
        gaps_on      = 1;
        repeat (4) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // empty volume after reset: every free is rejected, allocate finds nothing,
        // refill words without a pending chain read are dropped
        issue_word(cfbs_pkg::KIND_FREE, 32'h5, 0, 0);
        issue_word(cfbs_pkg::KIND_ALLOC, 0, 0, 0);
        issue_word(cfbs_pkg::KIND_REFILL_ENT, 32'h1234, 3, 0);
        issue_word(cfbs_pkg::KIND_REFILL_END, 0, 0, 5);

        // range edges, zero terminator seeding, popping down to the terminator
        set_volume(16, 4096);
        issue_word(cfbs_pkg::KIND_FREE, 16, 0, 0);
        issue_word(cfbs_pkg::KIND_FREE, 4095, 0, 0);
        issue_word(cfbs_pkg::KIND_FREE, 15, 0, 0);
        issue_word(cfbs_pkg::KIND_FREE, 4096, 0, 0);
        issue_word(cfbs_pkg::KIND_FREE, 32'hFFFF_FFFF, 0, 0);
        issue_word(cfbs_pkg::KIND_FREE, 0, 0, 0);
        issue_word(cfbs_pkg::KIND_ALLOC, 0, 0, 0);
        issue_word(cfbs_pkg::KIND_ALLOC, 0, 0, 0);
        issue_word(cfbs_pkg::KIND_ALLOC, 0, 0, 0);
        issue_word(cfbs_pkg::KIND_ALLOC, 0, 0, 0);
        issue_word(cfbs_pkg::KIND_FREE, 100, 0, 0);
        issue_word(cfbs_pkg::KIND_FREE, 200, 0, 0);

        // narrow the volume so the allocate after the grant skips block 100
        set_volume(150, 4096);
        issue_word(cfbs_pkg::KIND_ALLOC, 0, 0, 0);
        issue_word(cfbs_pkg::KIND_ALLOC, 0, 0, 0);

        // free-heavy first to reach spills, then drain to reach chain refills
        set_volume(16, 4096);
        run_traffic(120, 85);
        run_traffic(40, 25);
        drain_block();
        run_traffic(40, 25);

        // whole 32-bit space but for its top block, then a narrow window that strands stacked blocks
        set_volume(0, 32'hFFFF_FFFF);
        run_traffic(60, 55);
        set_volume(1000, 2000);
        run_traffic(50, 45);

        // top of the block number space, then an inverted range
        set_volume(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        run_traffic(20, 60);
        set_volume(32'h8000_0000, 32'h10);
        run_traffic(10, 50);

        // closing stretch at full rate on both sides
        set_volume(16, 4096);
        gaps_on = 0;
        run_traffic(60, 50);

        drain_block();
        if (board.errors == 0 && board.expected_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/cfbs_pkg.sv
hw/rtl/cfbs_stack_mem.sv
hw/rtl/cfbs_range_chk.sv
hw/rtl/chained_free_block_stack.sv
hw/rtl/cfbs_checker.sv
sim/testbench.sv
